FILE: sv/assert_macros.svh
// Assertion macros for the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge of clk, off during reset.
`define ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, sampled on the rising edge of clk, off during reset.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

FILE: sv/crtc_pkg.sv
// Package with the types, codes and constants of the relay countdown timer controller.
package crtc_pkg;

	typedef enum logic [2:0] {
		PH_RESET    = 3'd0,
		PH_STANDBY  = 3'd1,
		PH_START    = 3'd2,
		PH_COUNTING = 3'd3,
		PH_PAUSING  = 3'd4,
		PH_PAUSED   = 3'd5,
		PH_END      = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		SEQ_IDLE = 2'd0,
		SEQ_MUL  = 2'd1,
		SEQ_DIV  = 2'd2,
		SEQ_DONE = 2'd3
	} seq_t;

	localparam logic       OP_TICK = 1'b0;
	localparam logic       OP_PASS = 1'b1;

	localparam logic [2:0] BTN_NONE        = 3'd0;
	localparam logic [2:0] BTN_START_SHORT = 3'd1;
	localparam logic [2:0] BTN_START_LONG  = 3'd2;
	localparam logic [2:0] BTN_PLUS        = 3'd3;
	localparam logic [2:0] BTN_MINUS       = 3'd4;
	localparam logic [2:0] BTN_RELEASE     = 3'd5;

	localparam logic [2:0] REG_INITIAL_SET_TIME  = 3'd0;
	localparam logic [2:0] REG_DISPLAY_PIXELS    = 3'd1;
	localparam logic [2:0] REG_LIMIT_COUNTDOWN   = 3'd2;
	localparam logic [2:0] REG_LIMIT_SLOW_REPEAT = 3'd3;
	localparam logic [2:0] REG_LIMIT_FAST_REPEAT = 3'd4;
	localparam logic [2:0] REG_LIMIT_PICTURES    = 3'd5;
	localparam logic [2:0] REG_LIMIT_END_HOLD    = 3'd6;
	localparam logic [2:0] REG_LIMIT_IDLE        = 3'd7;

	localparam logic [9:0] RST_INITIAL_SET_TIME  = 10'd150;
	localparam logic [7:0] RST_DISPLAY_PIXELS    = 8'd128;
	localparam logic [7:0] RST_LIMIT_COUNTDOWN   = 8'd9;
	localparam logic [7:0] RST_LIMIT_SLOW_REPEAT = 8'd39;
	localparam logic [7:0] RST_LIMIT_FAST_REPEAT = 8'd9;
	localparam logic [7:0] RST_LIMIT_PICTURES    = 8'd39;
	localparam logic [7:0] RST_LIMIT_END_HOLD    = 8'd99;
	localparam logic [7:0] RST_LIMIT_IDLE        = 8'd99;

	localparam logic [7:0] PICTURE_FIRST = 8'd0;
	localparam logic [7:0] PICTURE_LAST  = 8'd7;
	localparam logic [9:0] MAX_SET_TIME  = 10'd999;
	localparam logic [9:0] MIN_SET_TIME  = 10'd1;
	localparam logic [6:0] IDLE_LAST     = 7'd119;
	localparam logic [2:0] SLOW_STEPS    = 3'd5;

	// Quotient bits of the progress divide, most significant first.
	localparam int unsigned QUOT_BITS = 8;

	function automatic logic [9:0] clamp_set(input logic [9:0] v);
		logic [9:0] r;
		r = v;
		if (v < MIN_SET_TIME) begin
			r = MIN_SET_TIME;
		end else if (v > MAX_SET_TIME) begin
			r = MAX_SET_TIME;
		end
		return r;
	endfunction

endpackage

FILE: sv/countdown_relay_timer_control.sv
// Top level of the relay countdown timer controller: event handling, state and progress divide.
// A request is taken in the idle state; the multiply state forms its progress numerator, the
// eight-step restoring divider for the progress bar divides it, one quotient bit a cycle, and
// the done state loads the result register once the output is free. A result still waiting
// at the output holds the done state, so no new request is taken before this one is loaded.
// Reset (arst_n low, asynchronous) puts the controller in the reset phase with the set time
// at 150 tenths, every counter cleared and configuration registers at documented defaults.
`include "assert_macros.svh"

module countdown_relay_timer_control
	import crtc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,

	input  logic       item_valid,
	output logic       item_ready,
	input  logic       opcode,
	input  logic [2:0] button,

	output logic       result_valid,
	input  logic       result_ready,
	output logic       relay_on,
	output logic [9:0] display_value,
	output logic [7:0] progress_pixels,
	output logic [2:0] phase_code,
	output logic       store_request,
	output logic [9:0] store_value,

	input  logic       wr_en,
	input  logic [2:0] wr_index,
	input  logic [9:0] wr_data
);

	// Configuration registers. The initial set time is not kept: a write to it loads the set
	// time straight away, saturated into the legal range.
	logic [7:0] display_pixels_q;
	logic [7:0] limit_countdown_q;
	logic [7:0] limit_slow_q;
	logic [7:0] limit_fast_q;
	logic [7:0] limit_pictures_q;
	logic [7:0] limit_end_hold_q;
	logic [7:0] limit_idle_q;

	// Controller state.
	phase_t     phase_q;
	logic [9:0] set_time_q;
	logic       set_changed_q;
	logic [9:0] remaining_q;
	logic [7:0] tick_count_q;
	logic [7:0] tick_limit_q;
	logic       end_hold_q;
	logic [2:0] repeat_q;
	logic [6:0] idle_q;
	logic [7:0] picture_q;
	logic       first_press_q;
	logic       relay_q;
	logic       pending_q;

	// Next values of the controller state for the request at the ports.
	phase_t     n_phase;
	logic [9:0] n_set;
	logic       n_chg;
	logic [9:0] n_rem;
	logic [7:0] n_tick;
	logic [7:0] n_lim;
	logic       n_eh;
	logic [2:0] n_rep;
	logic [6:0] n_idle;
	logic [7:0] n_pic;
	logic       n_first;
	logic       n_relay;
	logic       n_pend;

	// Sequencer and divider.
	seq_t       seq_q;
	seq_t       seq_d;
	logic       take_item;
	logic       load_result;
	logic [17:0] div_rem_q;
	logic [7:0] quot_q;
	logic [2:0] bit_q;
	logic [17:0] divisor_sh;
	logic       fits;
	logic       prog_en;
	logic [9:0] elapsed;
	logic [17:0] product;

	// Result registers.
	logic       res_valid_q;
	logic       relay_on_q;
	logic [9:0] display_q;
	logic [7:0] progress_q;
	logic [2:0] phase_code_q;
	logic       store_req_q;
	logic [9:0] store_val_q;

	assign take_item = item_valid && item_ready;

	// Configuration writes: the user sends them only while no request is in flight, unchecked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_pixels_q  <= RST_DISPLAY_PIXELS;
			limit_countdown_q <= RST_LIMIT_COUNTDOWN;
			limit_slow_q      <= RST_LIMIT_SLOW_REPEAT;
			limit_fast_q      <= RST_LIMIT_FAST_REPEAT;
			limit_pictures_q  <= RST_LIMIT_PICTURES;
			limit_end_hold_q  <= RST_LIMIT_END_HOLD;
			limit_idle_q      <= RST_LIMIT_IDLE;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_DISPLAY_PIXELS:    display_pixels_q  <= wr_data[7:0];
				REG_LIMIT_COUNTDOWN:   limit_countdown_q <= wr_data[7:0];
				REG_LIMIT_SLOW_REPEAT: limit_slow_q      <= wr_data[7:0];
				REG_LIMIT_FAST_REPEAT: limit_fast_q      <= wr_data[7:0];
				REG_LIMIT_PICTURES:    limit_pictures_q  <= wr_data[7:0];
				REG_LIMIT_END_HOLD:    limit_end_hold_q  <= wr_data[7:0];
				REG_LIMIT_IDLE:        limit_idle_q      <= wr_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Event handling for one request. A tick only advances the tick counter; for a pass the steps
	// run in order: the button event first, then the check for an exhausted countdown, then the
	// due action when the tick counter has reached the current limit.
	always_comb begin
		n_phase = phase_q;
		n_set   = set_time_q;
		n_chg   = set_changed_q;
		n_rem   = remaining_q;
		n_tick  = tick_count_q;
		n_lim   = tick_limit_q;
		n_eh    = end_hold_q;
		n_rep   = repeat_q;
		n_idle  = idle_q;
		n_pic   = picture_q;
		n_first = first_press_q;
		n_relay = relay_q;
		n_pend  = 1'b0;

		if (opcode == OP_TICK) begin
			n_tick = tick_count_q + 8'd1;
		end else begin
			if (button == BTN_START_SHORT || button == BTN_START_LONG) begin
				// Start, pause, or a long press that abandons a paused run.
				if (n_phase == PH_PAUSED && button == BTN_START_LONG) begin
					n_phase = PH_RESET;
					n_tick  = 8'd0;
				end else if (n_phase == PH_PAUSED || n_phase == PH_STANDBY ||
						n_phase == PH_RESET) begin
					n_phase = PH_START;
					n_lim   = limit_countdown_q;
					n_tick  = 8'd0;
					n_relay = 1'b1;
					if (n_rem != 10'd0) begin
						n_rem = n_rem - 10'd1;
					end
				end else if (n_phase == PH_COUNTING) begin
					n_phase = PH_PAUSING;
					n_lim   = 8'd0;
					n_relay = 1'b0;
				end
				n_idle = 7'd0;
			end else if (button == BTN_PLUS || button == BTN_MINUS) begin
				// Adjustment: one step on the first press, auto-repeat afterwards.
				if (n_phase == PH_RESET || n_phase == PH_PAUSED || n_phase == PH_STANDBY) begin
					if (n_phase == PH_STANDBY) begin
						n_phase = PH_RESET;
					end
					n_lim = (n_rep < SLOW_STEPS) ? limit_slow_q : limit_fast_q;
					if (!n_first) begin
						if (button == BTN_PLUS) begin
							if (n_phase != PH_PAUSED) begin
								if (n_set < MAX_SET_TIME) begin
									n_set = n_set + 10'd1;
									n_chg = 1'b1;
								end
							end else if (n_rem < n_set) begin
								n_rem = n_rem + 10'd1;
							end
						end else begin
							if (n_phase != PH_PAUSED) begin
								n_chg = 1'b1;
								if (n_set > MIN_SET_TIME) begin
									n_set = n_set - 10'd1;
								end
							end else if (n_rem > MIN_SET_TIME) begin
								n_rem = n_rem - 10'd1;
							end
						end
						n_tick  = 8'd0;
						n_first = 1'b1;
					end
					n_idle = 7'd0;
				end
			end else if (button == BTN_RELEASE) begin
				if (n_phase == PH_RESET) begin
					n_rem = n_set;
					n_lim = limit_idle_q;
				end else if (n_phase == PH_PAUSED) begin
					n_lim = limit_idle_q;
				end else if (n_phase == PH_PAUSING) begin
					n_phase = PH_PAUSED;
				end else if (n_phase == PH_START) begin
					n_phase = PH_COUNTING;
				end
				n_rep   = 3'd0;
				n_first = 1'b0;
			end

			// A run with nothing left goes to the end phase and drops the relay.
			if (n_rem == 10'd0 && n_phase != PH_END) begin
				n_phase = PH_END;
				n_lim   = limit_end_hold_q;
				n_relay = 1'b0;
			end

			if (n_lim != 8'd0) begin
				if (n_tick >= n_lim) begin
					if (n_phase == PH_COUNTING) begin
						if (n_rem != 10'd0) begin
							n_rem = n_rem - 10'd1;
						end
					end else if (n_phase == PH_END) begin
						if (!n_eh) begin
							n_eh = 1'b1;
						end else begin
							n_eh    = 1'b0;
							n_phase = PH_RESET;
						end
					end else if (button == BTN_PLUS) begin
						if (n_phase != PH_PAUSED) begin
							if (n_set < MAX_SET_TIME) begin
								n_set = n_set + 10'd1;
								n_chg = 1'b1;
							end
						end else if (n_rem < n_set) begin
							n_rem = n_rem + 10'd1;
						end
						if (n_rep < SLOW_STEPS) begin
							n_rep = n_rep + 3'd1;
						end
					end else if (button == BTN_MINUS) begin
						if (n_phase != PH_PAUSED) begin
							n_chg = 1'b1;
							if (n_set > MIN_SET_TIME) begin
								n_set = n_set - 10'd1;
							end
						end else if (n_rem > MIN_SET_TIME) begin
							n_rem = n_rem - 10'd1;
						end
						if (n_rep < SLOW_STEPS) begin
							n_rep = n_rep + 3'd1;
						end
					end else begin
						if (n_phase == PH_STANDBY) begin
							n_pic = (n_pic < PICTURE_LAST) ? n_pic + 8'd1 : PICTURE_FIRST;
						end
						if (n_phase == PH_PAUSED || n_phase == PH_RESET) begin
							if (n_idle < IDLE_LAST) begin
								n_idle = n_idle + 7'd1;
							end else begin
								// Idle timeout: drop to standby, and ask for the set time
								// to be saved if it was changed.
								n_rem = n_set;
								if (n_chg) begin
									n_pend = 1'b1;
									n_chg  = 1'b0;
								end
								n_phase = PH_STANDBY;
								n_pic   = PICTURE_FIRST;
								n_lim   = limit_pictures_q;
							end
						end
					end
					n_tick = 8'd0;
				end
			end else begin
				n_tick = 8'd0;
			end
		end
	end

	// State registers take the new values when a request is accepted. The set time is also
	// loaded by a configuration write of the initial set time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_RESET;
			set_time_q    <= clamp_set(RST_INITIAL_SET_TIME);
			set_changed_q <= 1'b0;
			remaining_q   <= 10'd0;
			tick_count_q  <= 8'd0;
			tick_limit_q  <= 8'd0;
			end_hold_q    <= 1'b0;
			repeat_q      <= 3'd0;
			idle_q        <= 7'd0;
			picture_q     <= PICTURE_FIRST;
			first_press_q <= 1'b0;
			relay_q       <= 1'b0;
			pending_q     <= 1'b0;
		end else if (take_item) begin
			phase_q       <= n_phase;
			set_time_q    <= n_set;
			set_changed_q <= n_chg;
			remaining_q   <= n_rem;
			tick_count_q  <= n_tick;
			tick_limit_q  <= n_lim;
			end_hold_q    <= n_eh;
			repeat_q      <= n_rep;
			idle_q        <= n_idle;
			picture_q     <= n_pic;
			first_press_q <= n_first;
			relay_q       <= n_relay;
			pending_q     <= n_pend;
		end else if (wr_en && wr_index == REG_INITIAL_SET_TIME) begin
			set_time_q <= clamp_set(wr_data);
		end
	end

	// Sequencer: take a request, form the progress numerator, divide it, hand it out.
	always_comb begin
		seq_d = seq_q;
		unique case (seq_q)
			SEQ_IDLE: begin
				if (item_valid) begin
					seq_d = SEQ_MUL;
				end
			end
			SEQ_MUL:  seq_d = SEQ_DIV;
			SEQ_DIV: begin
				if (bit_q == 3'd0) begin
					seq_d = SEQ_DONE;
				end
			end
			SEQ_DONE: begin
				if (!res_valid_q || result_ready) begin
					seq_d = SEQ_IDLE;
				end
			end
			default:  seq_d = SEQ_IDLE;
		endcase
	end

	always_comb begin
		item_ready  = 1'b0;
		load_result = 1'b0;
		unique case (seq_q)
			SEQ_IDLE: item_ready  = 1'b1;
			SEQ_DONE: load_result = !res_valid_q || result_ready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SEQ_IDLE;
		end else begin
			seq_q <= seq_d;
		end
	end

	// Progress is only shown while a run is under way and nothing exceeds the set time.
	assign prog_en = phase_q != PH_STANDBY && phase_q != PH_RESET && remaining_q <= set_time_q;
	assign elapsed = set_time_q - remaining_q;
	assign product = 18'(display_pixels_q) * 18'(elapsed);

	// Restoring divide: the quotient never exceeds the bar width, so eight bits suffice.
	assign divisor_sh = 18'(set_time_q) << bit_q;
	assign fits       = div_rem_q >= divisor_sh;

	always_ff @(posedge clk) begin
		if (seq_q == SEQ_MUL) begin
			div_rem_q <= prog_en ? product : 18'd0;
			quot_q    <= 8'd0;
			bit_q     <= 3'(QUOT_BITS - 1);
		end else if (seq_q == SEQ_DIV) begin
			if (fits) begin
				div_rem_q     <= div_rem_q - divisor_sh;
				quot_q[bit_q] <= 1'b1;
			end
			bit_q <= bit_q - 3'd1;
		end
	end

	// Output register: holds a finished result until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_result) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_result) begin
			relay_on_q   <= relay_q;
			progress_q   <= quot_q;
			phase_code_q <= phase_q;
			store_req_q  <= pending_q;
			store_val_q  <= pending_q ? set_time_q : 10'd0;
			if (phase_q == PH_STANDBY) begin
				display_q <= 10'(picture_q);
			end else if (phase_q == PH_RESET) begin
				display_q <= set_time_q;
			end else begin
				display_q <= remaining_q;
			end
		end
	end

	assign result_valid    = res_valid_q;
	assign relay_on        = relay_on_q;
	assign display_value   = display_q;
	assign progress_pixels = progress_q;
	assign phase_code      = phase_code_q;
	assign store_request   = store_req_q;
	assign store_value     = store_val_q;

	// A save request only ever goes out with the entry to standby.
	`ASSERT_IMPLIES(a_store_in_standby, result_valid && store_request,
		phase_code == PH_STANDBY)
	// The divider never produces more pixels than the bar is wide.
	`ASSERT_IMPLIES(a_progress_bound, seq_q == SEQ_DONE, quot_q <= display_pixels_q)
	// The relay is driven only while a run is starting or counting.
	`ASSERT_IMPLIES(a_relay_phase, relay_q, phase_q == PH_START || phase_q == PH_COUNTING)

endmodule
